// ===== rtl/core/sha1md_pkg.sv =====
// Shared constants and types of the SHA-1 digest block.
`default_nettype none

package sha1md_pkg;

   localparam int BLOCK_WORDS  = 16;
   localparam int WORD_ADDR_W  = 4;
   localparam int DIGEST_WORDS = 5;
   localparam int COUNT_W      = 61;

   localparam logic [6:0] BLOCK_BYTES = 7'd64;
   localparam logic [5:0] PAD_LIMIT   = 6'd56;
   localparam logic [6:0] LAST_ROUND  = 7'd79;
   localparam logic [7:0] PAD_MARKER  = 8'h80;

   localparam logic [31:0] ROUND_K0 = 32'h5A827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;

   // Word 0 is H0.
   localparam logic [DIGEST_WORDS-1:0][31:0] CHAIN_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   // How a block is assembled from stored bytes and padding.
   typedef struct packed {
      logic [6:0] data_count;  // bytes below this come from the store
      logic       marker;      // put the pad marker at data_count
      logic       length;      // put the bit length in the last eight bytes
   } blk_mode_type;

   typedef struct packed {
      logic         start;
      logic         chain_init;
      blk_mode_type mode;
   } cmp_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cmp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/sha1md_req_if.sv =====
// Input channel: one message byte with its flags.
`default_nettype none

interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, message_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha1md_rsp_if.sv =====
// Result channel: one digest word with its position.
`default_nettype none

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        final_word;

   modport source (output valid, digest_word, word_index, final_word, input ready);
   modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha1md_block_ram.sv =====
// Block store: 16 x 32-bit words, byte-lane writes, one registered read port.
`default_nettype none

module sha1md_block_ram (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [sha1md_pkg::WORD_ADDR_W-1:0]  wr_addr,
   input  wire logic [3:0]                          wr_be,
   input  wire logic [31:0]                         wr_data,
   input  wire logic [sha1md_pkg::WORD_ADDR_W-1:0]  rd_addr,
   output logic      [31:0]                         rd_data
);

   logic [31:0] mem [sha1md_pkg::BLOCK_WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int k = 0; k < 4; k++) begin
            if (wr_be[k]) begin
               mem[wr_addr][8*k +: 8] <= wr_data[8*k +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/sha1md_compress.sv =====
// Compression engine: schedule window, one round per cycle, chain value.
`default_nettype none

module sha1md_compress (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sha1md_pkg::cmp_cmd_type             cmd,
   input  wire logic [63:0]                         msg_bits,
   input  wire logic [31:0]                         ram_rdata,
   output logic      [sha1md_pkg::WORD_ADDR_W-1:0]  ram_raddr,
   output sha1md_pkg::cmp_stat_type                 stat,
   output logic      [sha1md_pkg::DIGEST_WORDS-1:0][31:0] digest
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_LOAD  = 2'd1;
   localparam logic [1:0] PH_RUN   = 2'd2;
   localparam logic [1:0] PH_FINAL = 2'd3;

   logic [1:0]                       phase_ff, phase_in;
   logic [6:0]                       round_ff, round_in;
   sha1md_pkg::blk_mode_type         mode_ff, mode_in;
   logic [sha1md_pkg::DIGEST_WORDS-1:0][31:0] work_ff, work_in;
   logic [sha1md_pkg::DIGEST_WORDS-1:0][31:0] chain_ff, chain_in;
   logic [sha1md_pkg::BLOCK_WORDS-1:0][31:0]  sched_ff, sched_in;

   logic [31:0] w_block, w_expand, w_new, f_val, k_val, temp;

   // Assemble word t from stored bytes, marker, zeros and bit length.
   always_comb begin : pad_mux
      logic [5:0]  pos;
      logic [31:0] len_word;
      len_word = round_ff[0] ? msg_bits[31:0] : msg_bits[63:32];
      w_block  = '0;
      for (int j = 0; j < 4; j++) begin
         pos = {round_ff[3:0], 2'(j)};
         if ({1'b0, pos} < mode_ff.data_count) begin
            w_block[31-8*j -: 8] = ram_rdata[31-8*j -: 8];
         end else if (mode_ff.marker && pos == mode_ff.data_count[5:0]) begin
            w_block[31-8*j -: 8] = sha1md_pkg::PAD_MARKER;
         end else if (mode_ff.length && pos >= sha1md_pkg::PAD_LIMIT) begin
            w_block[31-8*j -: 8] = len_word[31-8*j -: 8];
         end
      end
   end

   assign w_expand = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   assign w_new    = (round_ff < 7'(sha1md_pkg::BLOCK_WORDS))
                     ? w_block : {w_expand[30:0], w_expand[31]};

   always_comb begin
      if (round_ff inside {[7'd0:7'd19]}) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = sha1md_pkg::ROUND_K0;
      end else if (round_ff inside {[7'd20:7'd39]}) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = sha1md_pkg::ROUND_K1;
      end else if (round_ff inside {[7'd40:7'd59]}) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = sha1md_pkg::ROUND_K2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = sha1md_pkg::ROUND_K3;
      end
   end

   assign temp = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + k_val + w_new;

   always_comb begin
      phase_in = phase_ff;
      round_in = round_ff;
      mode_in  = mode_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      sched_in = sched_ff;
      if (cmd.chain_init) begin
         chain_in = sha1md_pkg::CHAIN_INIT;
      end
      case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               mode_in  = cmd.mode;
               phase_in = PH_LOAD;
            end
         end
         PH_LOAD: begin
            work_in  = chain_ff;
            round_in = '0;
            phase_in = PH_RUN;
         end
         PH_RUN: begin
            work_in[0] = temp;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            for (int k = 0; k < sha1md_pkg::BLOCK_WORDS - 1; k++) begin
               sched_in[k] = sched_ff[k+1];
            end
            sched_in[sha1md_pkg::BLOCK_WORDS-1] = w_new;
            round_in = round_ff + 7'd1;
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               phase_in = PH_FINAL;
            end
         end
         PH_FINAL: begin
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         chain_ff <= sha1md_pkg::CHAIN_INIT;
      end else begin
         phase_ff <= phase_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      mode_ff  <= mode_in;
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   // Fetch word t+1 during round t so it lands as round t+1 starts.
   assign ram_raddr = (phase_ff == PH_RUN)
                      ? round_ff[sha1md_pkg::WORD_ADDR_W-1:0] + 4'd1 : '0;

   assign stat.busy = (phase_ff != PH_IDLE);
   assign stat.done = (phase_ff == PH_FINAL);
   assign digest    = chain_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sha1_message_digest_top.sv =====
// SHA-1 digest block: byte intake, padding control, digest output buffer.
//
//   channel | dir | handshake         | payload
//   req     | in  | valid/ready       | message_byte, byte_present, end_of_message
//   rsp     | out | valid/ready       | digest_word, word_index, final_word
//
// A byte is taken only while the block is idle. The 64th byte of a block starts a
// compression (a load, 80 rounds, a chain update) on the round engine,
// during which req.ready is low. A finishing item adds one or two compressions,
// each started from its own padding state, and a hand-off of the digest to the
// five-word output buffer.
// Reset is synchronous and restores the initial chain value; the block store
// is not cleared. Bytes of the next message are taken while the buffer drains;
// a new digest waits for the buffer to empty.
`default_nettype none

module sha1_message_digest_top (
   input wire logic   clock,
   input wire logic   reset,
   sha1md_req_if.sink   req,
   sha1md_rsp_if.source rsp
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DATA  = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_EXTRA = 3'd3;
   localparam logic [2:0] ST_TAIL  = 3'd4;
   localparam logic [2:0] ST_LAST  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   localparam logic [2:0] OUT_FULL = 3'(sha1md_pkg::DIGEST_WORDS);

   logic [2:0]                          state_ff, state_in;
   logic [5:0]                          fill_ff, fill_in;
   logic [sha1md_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                                eom_pend_ff, eom_pend_in;
   logic [sha1md_pkg::DIGEST_WORDS-1:0][31:0] out_ff, out_in;
   logic [2:0]                          out_cnt_ff, out_cnt_in;

   logic                                req_accept, rsp_accept, emit_load;
   logic                                ram_we;
   logic [31:0]                         ram_rdata;
   logic [sha1md_pkg::WORD_ADDR_W-1:0]  ram_raddr;
   sha1md_pkg::cmp_cmd_type             cmd;
   sha1md_pkg::cmp_stat_type            core_stat;
   logic [sha1md_pkg::DIGEST_WORDS-1:0][31:0] digest;

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign rsp_accept = rsp.valid && rsp.ready;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      eom_pend_in = eom_pend_ff;
      cmd         = '0;
      ram_we      = 1'b0;
      emit_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req.byte_present) begin
                  ram_we   = 1'b1;
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (req.byte_present && (&fill_ff)) begin
                  // Block full: compress it before any padding.
                  cmd.start           = 1'b1;
                  cmd.mode.data_count = sha1md_pkg::BLOCK_BYTES;
                  eom_pend_in         = req.end_of_message;
                  state_in            = ST_DATA;
               end else if (req.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_DATA: begin
            if (core_stat.done) begin
               state_in = eom_pend_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.start           = 1'b1;
            cmd.mode.data_count = {1'b0, fill_ff};
            cmd.mode.marker     = 1'b1;
            cmd.mode.length     = (fill_ff < sha1md_pkg::PAD_LIMIT);
            state_in            = (fill_ff < sha1md_pkg::PAD_LIMIT) ? ST_LAST : ST_EXTRA;
         end
         ST_EXTRA: begin
            if (core_stat.done) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            // Extra block: zeros and the bit length only.
            cmd.start       = 1'b1;
            cmd.mode.length = 1'b1;
            state_in        = ST_LAST;
         end
         ST_LAST: begin
            if (core_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_cnt_ff == '0) begin
               emit_load      = 1'b1;
               cmd.chain_init = 1'b1;
               fill_in        = '0;
               count_in       = '0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_in     = out_ff;
      out_cnt_in = out_cnt_ff;
      if (emit_load) begin
         out_in     = digest;
         out_cnt_in = OUT_FULL;
      end else if (rsp_accept) begin
         for (int i = 0; i < sha1md_pkg::DIGEST_WORDS - 1; i++) begin
            out_in[i] = out_ff[i+1];
         end
         out_cnt_in = out_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         count_ff    <= '0;
         eom_pend_ff <= 1'b0;
         out_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         eom_pend_ff <= eom_pend_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp.valid       = (out_cnt_ff != '0);
   assign rsp.digest_word = out_ff[0];
   assign rsp.word_index  = OUT_FULL - out_cnt_ff;
   assign rsp.final_word  = (out_cnt_ff == 3'd1);

   sha1md_block_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[5:2]),
      .wr_be   (4'b1000 >> fill_ff[1:0]),
      .wr_data ({4{req.message_byte}}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sha1md_compress u_compress (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .msg_bits  ({count_ff, 3'b000}),
      .ram_rdata (ram_rdata),
      .ram_raddr (ram_raddr),
      .stat      (core_stat),
      .digest    (digest)
   );

   a_no_write_in_compress: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !core_stat.busy)
      else $error("byte written while a block is being compressed");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !core_stat.busy)
      else $error("compression started while engine busy");

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_cnt_ff == '0) |=>
         (out_cnt_ff == OUT_FULL && fill_ff == '0 && count_ff == '0))
      else $error("digest hand-off did not load buffer and clear message state");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the SHA-1 digest block: byte stream in, five-word digests out.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic clock;
   logic reset;

   sha1md_req_if req_ch ();
   sha1md_rsp_if rsp_ch ();

   sha1_message_digest_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Predicted hash state
   logic [31:0]                    chain_state [sha1md_pkg::DIGEST_WORDS];
   logic [7:0]                     block_bytes [64];
   logic [6:0]                     fill_count;
   logic [sha1md_pkg::COUNT_W-1:0] byte_total;
   digest_word_type                predicted_words [$];

   int fail_count;
   int messages_sent;
   int bytes_sent;
   int ignored_items;
   int words_checked;
   int data_items;
   int rsp_hold_request;
   bit gaps_on;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("sha1_message_digest_top verification failed");
      $finish;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void sha1_restart();
      for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
         chain_state[i] = sha1md_pkg::CHAIN_INIT[i];
      fill_count = '0;
      byte_total = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < sha1md_pkg::BLOCK_WORDS; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = sha1md_pkg::BLOCK_WORDS; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain_state[0];
      b = chain_state[1];
      c = chain_state[2];
      d = chain_state[3];
      e = chain_state[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::ROUND_K0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = sha1md_pkg::ROUND_K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1md_pkg::ROUND_K3;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_state[0] += a;
      chain_state[1] += b;
      chain_state[2] += c;
      chain_state[3] += d;
      chain_state[4] += e;
   endfunction

   // Take one accepted item; on a finishing item pad and queue the digest words.
   function automatic void sha1_absorb(input logic [7:0] data, input logic present,
                                       input logic finish);
      logic [63:0]     len_bits;
      digest_word_type w;
      if (present) begin
         block_bytes[fill_count[5:0]] = data;
         fill_count = fill_count + 7'd1;
         byte_total++;
         if (fill_count == sha1md_pkg::BLOCK_BYTES) begin
            sha1_compress();
            fill_count = '0;
         end
      end
      if (!finish) return;
      block_bytes[fill_count[5:0]] = sha1md_pkg::PAD_MARKER;
      fill_count = fill_count + 7'd1;
      // no room for the length: close this block and pad a fresh one
      if (fill_count > {1'b0, sha1md_pkg::PAD_LIMIT}) begin
         for (int i = int'(fill_count); i < 64; i++) block_bytes[i] = 8'h00;
         sha1_compress();
         fill_count = '0;
      end
      for (int i = int'(fill_count); i < int'(sha1md_pkg::PAD_LIMIT); i++)
         block_bytes[i] = 8'h00;
      len_bits = {byte_total, 3'b000};
      for (int i = 0; i < 8; i++) block_bytes[56 + i] = len_bits[63 - 8*i -: 8];
      sha1_compress();
      for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
         w.word  = chain_state[i];
         w.index = i[2:0];
         w.last  = (i == sha1md_pkg::DIGEST_WORDS - 1);
         predicted_words.push_back(w);
      end
      sha1_restart();
   endfunction

   function automatic void check_field(input string name, input logic [31:0] expected,
                                       input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %08h, got %08h", name, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      digest_word_type expected;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_words.size() == 0) begin
            $error("digest_word: expected nothing, got %08h", rsp_ch.digest_word);
            fail_count++;
         end else begin
            expected = predicted_words.pop_front();
            check_field("digest_word", expected.word, rsp_ch.digest_word);
            check_field("word_index", 32'(expected.index), 32'(rsp_ch.word_index));
            check_field("final_word", 32'(expected.last), 32'(rsp_ch.final_word));
            words_checked++;
         end
      end
   end

   // Result side: a rotating stall pattern, re-drawn when its phase counter runs out, plus long holds on request.
   initial begin : receiver
      logic [7:0] pattern;
      int hold_left;
      int phase;
      rsp_ch.ready = 1'b0;
      pattern = 8'hFF;
      hold_left = 0;
      phase = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (phase == 0) begin
            case ($urandom_range(0, 3))
               0: pattern = 8'hFF;
               1: pattern = 8'($urandom_range(1, 255));
               default: pattern = 8'($urandom_range(0, 255));
            endcase
            phase = 32;
         end
         phase--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= pattern[0];
         end
         pattern = {pattern[0], pattern[7:1]};
      end
   end

   task automatic send_byte_item(input logic [7:0] data, input logic present, input logic finish);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_ch.valid          <= 1'b1;
      req_ch.message_byte   <= data;
      req_ch.byte_present   <= present;
      req_ch.end_of_message <= finish;
      do @(posedge clock); while (!req_ch.ready);
      sha1_absorb(data, present, finish);
      if (present) bytes_sent++;
      if (finish) messages_sent++;
      if (present || finish) data_items++;
      else ignored_items++;
   endtask

   // Drop valid and hold until every predicted word has come back.
   task automatic wait_for_digests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (predicted_words.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int len, input bit empty_finish, input int noise_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_byte_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_byte_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_finish);
      end
      if (len == 0 || empty_finish) send_byte_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic test_directed();
      gaps_on = 1'b0;
      send_byte_item(8'h00, 1'b0, 1'b1);   // empty message
      send_byte_item(8'h5A, 1'b0, 1'b0);   // no byte, no end: ignored
      send_byte_item(8'h00, 1'b1, 1'b1);
      send_byte_item(8'hFF, 1'b1, 1'b1);
      send_byte_item(8'h61, 1'b1, 1'b0);   // "abc" with an ignored item inside
      send_byte_item(8'h62, 1'b1, 1'b0);
      send_byte_item(8'hC3, 1'b0, 1'b0);
      send_byte_item(8'h63, 1'b1, 1'b1);
      send_byte_item(8'h80, 1'b1, 1'b0);   // bytes closed by an empty end item
      send_byte_item(8'h7F, 1'b1, 1'b0);
      send_byte_item(8'h11, 1'b0, 1'b1);
      send_byte_item(8'hA5, 1'b0, 1'b1);   // two empty messages back to back
      send_byte_item(8'h3C, 1'b0, 1'b1);
      wait_for_digests();
   endtask

   task automatic test_block_boundaries();
      gaps_on = 1'b1;
      send_message(56, 1'b0, 0);   // length needs an extra block
      send_message(64, 1'b0, 0);   // block full on the finishing byte
      wait_for_digests();
   endtask

   task automatic test_output_backpressure();
      gaps_on = 1'b0;
      rsp_hold_request = 400;
      repeat (5) send_message($urandom_range(1, 4), 1'b0, 0);
      wait_for_digests();
   endtask

   task automatic test_random_messages();
      int start_items;
      int start_messages;
      int r;
      int len;
      start_items = data_items;
      start_messages = messages_sent;
      while (data_items - start_items < 60 || messages_sent - start_messages < 4) begin
         r = $urandom_range(0, 99);
         if (r < 60) len = $urandom_range(0, 8);
         else if (r < 90) len = $urandom_range(9, 30);
         else len = $urandom_range(52, 66);
         gaps_on = ($urandom_range(0, 9) < 7);
         send_message(len, $urandom_range(0, 3) == 0, 10);
      end
      wait_for_digests();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.message_byte = 8'h00;
      req_ch.byte_present = 1'b0;
      req_ch.end_of_message = 1'b0;
      fail_count = 0;
      messages_sent = 0;
      bytes_sent = 0;
      ignored_items = 0;
      words_checked = 0;
      data_items = 0;
      rsp_hold_request = 0;
      gaps_on = 1'b0;
      burst_left = 0;
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      sha1_restart();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_block_boundaries();
      test_output_backpressure();
      test_random_messages();

      // let up to two trailing compressions finish; nothing more may appear
      repeat (200) @(posedge clock);
      if (predicted_words.size() != 0) begin
         $error("digest_word: %0d expected words never arrived", predicted_words.size());
         fail_count++;
      end
      $display("Hashed %0d messages, %0d bytes, %0d ignored items; checked %0d digest words.",
               messages_sent, bytes_sent, ignored_items, words_checked);
      $display("Run included empty and block-boundary messages and a 400-cycle output stall.");
      if (fail_count == 0) begin
         $display("sha1_message_digest_top verification clean");
      end else begin
         $display("sha1_message_digest_top verification failed");
      end
      $finish;
   end

endmodule
